### sv/sfcc_pkg.sv
// package for the sensor frame crc check and convert block
// types, constants and the crc-8 / divide-by-65535 helpers; no dependencies
package sfcc_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic [2:0] BYTE_TEMP_MSB = 3'd0;
    localparam logic [2:0] BYTE_TEMP_LSB = 3'd1;
    localparam logic [2:0] BYTE_TEMP_CRC = 3'd2;
    localparam logic [2:0] BYTE_HUM_MSB  = 3'd3;
    localparam logic [2:0] BYTE_HUM_LSB  = 3'd4;
    localparam logic [2:0] BYTE_HUM_CRC  = 3'd5;

    localparam int TPROD_W = 28;
    localparam int HPROD_W = 30;

    localparam logic [11:0] SCALE_C = 12'd1750;
    localparam logic [11:0] SCALE_F = 12'd3150;
    localparam logic [13:0] SCALE_H = 14'd10000;
    localparam logic [TPROD_W-1:0] OFFSET_C = TPROD_W'(450 * 65535);
    localparam logic [TPROD_W-1:0] OFFSET_F = TPROD_W'(490 * 65535);

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_t;

    typedef struct packed {
        logic signed [12:0] temperature_tenths;
        logic [13:0]        humidity_hundredths;
        logic               frame_status;
    } out_t;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [15:0] raw_humidity;
        logic        crc_error;
        logic        temp_unit;
    } frame_t;

    typedef struct packed {
        logic [TPROD_W-1:0] temp_prod;
        logic [HPROD_W-1:0] hum_prod;
        logic               crc_error;
        logic               temp_unit;
    } prod_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^30
    function automatic logic [14:0] div65535(input logic [HPROD_W-1:0] x);
        logic [HPROD_W:0] s;
        s = {1'b0, x} + (HPROD_W+1)'(x >> 16) + (HPROD_W+1)'(1);
        return s[HPROD_W:16];
    endfunction

endpackage

### sv/sfcc_frame.sv
// byte assembler: byte index, running crc-8, raw words and the unit register
// depends on sfcc_pkg
module sfcc_frame
    import sfcc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  in_t    in_data,
    input  logic   cfg_we,
    input  logic   cfg_wdata,
    output logic   frm_valid,
    input  logic   frm_ready,
    output frame_t frm_data
);

    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  crc_reg, crc_next;
    logic        err_reg, err_next;
    logic [15:0] rawt_reg, rawt_next;
    logic [15:0] rawh_reg, rawh_next;
    logic        unit_reg;
    logic        frm_v_reg, frm_v_next;
    frame_t      frm_reg, frm_next;

    logic [2:0]  idx_eff;
    logic [7:0]  crc_base;
    logic        err_base;
    logic [7:0]  crc_upd;
    logic        accept;

    assign in_ready  = !frm_v_reg || frm_ready;
    assign accept    = in_valid && in_ready;
    assign frm_valid = frm_v_reg;
    assign frm_data  = frm_reg;

    always_comb
    begin
        idx_eff  = (in_data.frame_start || idx_reg > BYTE_HUM_CRC) ? BYTE_TEMP_MSB : idx_reg;
        crc_base = (idx_eff == BYTE_TEMP_MSB) ? CRC_INIT : crc_reg;
        err_base = (idx_eff == BYTE_TEMP_MSB) ? 1'b0 : err_reg;
        crc_upd  = crc8_update(crc_base, in_data.rx_byte);

        idx_next   = idx_reg;
        crc_next   = crc_reg;
        err_next   = err_reg;
        rawt_next  = rawt_reg;
        rawh_next  = rawh_reg;
        frm_next   = frm_reg;
        frm_v_next = frm_v_reg && !frm_ready;

        if (accept)
        begin
            err_next = err_base;
            unique case (idx_eff)
                BYTE_TEMP_MSB:
                begin
                    rawt_next = {in_data.rx_byte, rawt_reg[7:0]};
                    crc_next  = crc_upd;
                end
                BYTE_TEMP_LSB:
                begin
                    rawt_next = {rawt_reg[15:8], in_data.rx_byte};
                    crc_next  = crc_upd;
                end
                BYTE_HUM_MSB:
                begin
                    rawh_next = {in_data.rx_byte, rawh_reg[7:0]};
                    crc_next  = crc_upd;
                end
                BYTE_HUM_LSB:
                begin
                    rawh_next = {rawh_reg[15:8], in_data.rx_byte};
                    crc_next  = crc_upd;
                end
                default:
                begin
                    // crc byte of either word
                    err_next = err_base || (in_data.rx_byte != crc_base);
                    crc_next = CRC_INIT;
                end
            endcase

            if (idx_eff == BYTE_HUM_CRC)
            begin
                idx_next                 = BYTE_TEMP_MSB;
                frm_v_next               = 1'b1;
                frm_next.raw_temperature = rawt_reg;
                frm_next.raw_humidity    = rawh_reg;
                frm_next.crc_error       = err_next;
                frm_next.temp_unit       = unit_reg;
            end
            else
            begin
                idx_next = idx_eff + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= BYTE_TEMP_MSB;
            crc_reg   <= CRC_INIT;
            err_reg   <= 1'b0;
            rawt_reg  <= '0;
            rawh_reg  <= '0;
            unit_reg  <= 1'b0;
            frm_v_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            err_reg   <= err_next;
            rawt_reg  <= rawt_next;
            rawh_reg  <= rawh_next;
            frm_v_reg <= frm_v_next;
            if (cfg_we)
            begin
                unit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        frm_reg <= frm_next;
    end

endmodule

### sv/sfcc_mul.sv
// product stage: raw words times their unit scale, registered
// depends on sfcc_pkg
module sfcc_mul
    import sfcc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  frame_t up_data,
    output logic   dn_valid,
    input  logic   dn_ready,
    output prod_t  dn_data
);

    logic  v_reg, v_next;
    prod_t p_reg, p_next;
    logic  load;

    assign up_ready = !v_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = v_reg;
    assign dn_data  = p_reg;

    always_comb
    begin
        v_next = v_reg && !dn_ready;
        p_next = p_reg;
        if (load)
        begin
            v_next = 1'b1;
            p_next.temp_prod = up_data.temp_unit
                ? TPROD_W'(SCALE_F) * TPROD_W'(up_data.raw_temperature)
                : TPROD_W'(SCALE_C) * TPROD_W'(up_data.raw_temperature);
            p_next.hum_prod  = HPROD_W'(SCALE_H) * HPROD_W'(up_data.raw_humidity);
            p_next.crc_error = up_data.crc_error;
            p_next.temp_unit = up_data.temp_unit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

endmodule

### sv/sfcc_div.sv
// offset, divide by full scale, sign and the result register
// depends on sfcc_pkg
module sfcc_div
    import sfcc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_ready,
    input  prod_t up_data,
    output logic  out_valid,
    input  logic  out_ready,
    output out_t  out_data
);

    logic               v_reg, v_next;
    out_t               o_reg, o_next;
    logic               load;
    logic [TPROD_W-1:0] offs;
    logic               below;
    logic [TPROD_W-1:0] diff;
    logic [14:0]        tq;
    logic [14:0]        hq;
    logic [12:0]        tmag;

    assign up_ready  = !v_reg || out_ready;
    assign load      = up_valid && up_ready;
    assign out_valid = v_reg;
    assign out_data  = o_reg;

    always_comb
    begin
        offs  = up_data.temp_unit ? OFFSET_F : OFFSET_C;
        below = up_data.temp_prod < offs;
        diff  = below ? (offs - up_data.temp_prod) : (up_data.temp_prod - offs);
        tq    = div65535(HPROD_W'(diff));
        hq    = div65535(up_data.hum_prod);
        tmag  = tq[12:0];

        v_next = v_reg && !out_ready;
        o_next = o_reg;
        if (load)
        begin
            v_next                     = 1'b1;
            o_next.temperature_tenths  = below ? $signed(~tmag + 13'd1) : $signed(tmag);
            o_next.humidity_hundredths = hq[13:0];
            o_next.frame_status        = up_data.crc_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_reg <= o_next;
    end

endmodule

### sv/sensor_frame_crc_check_convert.sv
// sensor reply crc check and convert, top level
// after the sixth byte's transfer, its frame passes the frame, product and result
// registers of the three-stage assemble/multiply/divide pipeline to out_valid
// throughput: one byte per cycle while out_ready does not stall the pipeline
// reset: byte index, crc, unit register and all stage valids cleared asynchronously
// depends on sfcc_pkg, sfcc_frame, sfcc_mul, sfcc_div
module sensor_frame_crc_check_convert
    import sfcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data,
    input  logic cfg_we,
    input  logic cfg_wdata
);

    logic   frm_valid, frm_ready;
    frame_t frm_data;
    logic   prd_valid, prd_ready;
    prod_t  prd_data;

    sfcc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm_data  (frm_data)
    );

    sfcc_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (frm_valid),
        .up_ready (frm_ready),
        .up_data  (frm_data),
        .dn_valid (prd_valid),
        .dn_ready (prd_ready),
        .dn_data  (prd_data)
    );

    sfcc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (prd_valid),
        .up_ready  (prd_ready),
        .up_data   (prd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### sv/sfcc_checker.sv
// port-level checks for the sensor frame crc check and convert block
// depends on sfcc_pkg; bound to sensor_frame_crc_check_convert
module sfcc_checker
    import sfcc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // stalled byte holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("byte changed while stalled");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.humidity_hundredths <= 14'd10000)
        else $error("humidity out of range");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.temperature_tenths >= -13'sd490)
                   && (out_data.temperature_tenths <= 13'sd2660))
        else $error("temperature out of range");

    // a fresh result follows a byte transfer through the three stages
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 3))
        else $error("result without a matching byte transfer");

endmodule

bind sensor_frame_crc_check_convert sfcc_checker u_sfcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
